// ----- rtl/ppce_pkg.sv -----
// Package for the palette pixel composite encoder.
// Holds shared types, level and emphasis tables and arithmetic constants.
// No dependencies.
`default_nettype none

package ppce_pkg;

  // field and register widths
  localparam int PIXEL_W   = 9;
  localparam int PHASE_W   = 4;
  localparam int LEVEL_W   = 8;
  localparam int OFFSET_W  = 20;
  localparam int GAIN_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;
  localparam int TABLE_W   = 18;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_GAIN   = 2'd1;

  // reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd100;

  // hue codes with fixed behavior
  localparam logic [3:0] HUE_MUTE_MIN    = 4'he;
  localparam logic [3:0] HUE_ALWAYS_HIGH = 4'd0;
  localparam logic [3:0] HUE_ALWAYS_LOW  = 4'd13;

  // color phase arithmetic
  localparam logic [4:0] PHASE_MOD   = 5'd12;
  localparam logic [4:0] PHASE_MOD2  = 5'd24;
  localparam logic [4:0] PHASE_STEP  = 5'd3;
  localparam logic [4:0] HALF_CYCLE  = 5'd6;
  localparam logic [3:0] WINDOW_MOD  = 4'd6;
  localparam int         SUBSAMPLES  = 4;

  // divide by 100: reciprocal floor(2^32 / 100) and one correction step
  localparam int          RECIP_SHIFT = 32;
  localparam logic [25:0] RECIP_100   = 26'd42949672;
  localparam logic [6:0]  DIV_CONST   = 7'd100;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // level table, index is {high, emphasis, luma[1:0]}
  localparam logic signed [TABLE_W-1:0] LEVEL_TABLE [16] = '{
    -18'sd12042, 18'sd0,      18'sd34406,  18'sd81427,
    -18'sd17203, -18'sd8028,  18'sd19497,  18'sd57342,
    18'sd43581,  18'sd75693,  18'sd112965, 18'sd112965,
    18'sd26951,  18'sd52181,  18'sd83721,  18'sd83721
  };

  // one classified pixel: four table indexes and a mute flag
  typedef struct packed {
    logic            mute;
    logic [3:0][3:0] idx;
  } op_t;

  // emphasis bits (red, green, blue as bits 0..2) active in each window
  function automatic logic [2:0] emph_window(input logic [2:0] win);
    logic [2:0] mask;
    mask = '0;
    unique case (win)
      3'd0:    mask = 3'b011;
      3'd1:    mask = 3'b001;
      3'd2:    mask = 3'b101;
      3'd3:    mask = 3'b100;
      3'd4:    mask = 3'b110;
      3'd5:    mask = 3'b010;
      default: mask = 3'b000;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ppce_front.sv -----
// Front end: accepts pixels, tracks the color phase and classifies the
// four subsamples into level table indexes. Uses ppce_pkg.
`default_nettype none

module ppce_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ppce_pkg::PIXEL_W-1:0]  pixel_i,
  input  wire logic                          load_phase_i,
  input  wire logic [ppce_pkg::PHASE_W-1:0]  start_phase_i,
  output logic                               push_valid_o,
  input  wire logic                          push_ready_i,
  output ppce_pkg::op_t                      push_data_o
);

  logic [ppce_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [ppce_pkg::PHASE_W-1:0] phase_cur;
  logic [4:0]                   phase_adv;
  logic [3:0]                   hue;
  logic [4:0]                   sub_q   [ppce_pkg::SUBSAMPLES];
  logic [4:0]                   wave_s  [ppce_pkg::SUBSAMPLES];
  logic [4:0]                   wave_m  [ppce_pkg::SUBSAMPLES];
  logic [3:0]                   win_raw [ppce_pkg::SUBSAMPLES];
  logic [3:0]                   win_m   [ppce_pkg::SUBSAMPLES];
  logic                         high    [ppce_pkg::SUBSAMPLES];
  logic                         emph    [ppce_pkg::SUBSAMPLES];

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign hue          = pixel_i[3:0];

  // pick the phase for this word and advance it by three, modulo twelve
  always_comb begin
    phase_cur = load_phase_i ? start_phase_i : phase_q;
    phase_adv = 5'(phase_cur) + ppce_pkg::PHASE_STEP;
    if (phase_adv >= ppce_pkg::PHASE_MOD) begin
      phase_adv = phase_adv - ppce_pkg::PHASE_MOD;
    end
    phase_d = phase_adv[ppce_pkg::PHASE_W-1:0];
  end

  // classify each subsample: wave level and emphasis window
  always_comb begin
    for (int k = 0; k < ppce_pkg::SUBSAMPLES; k++) begin
      sub_q[k]  = 5'(phase_cur) + 5'(k);
      wave_s[k] = 5'(hue) + sub_q[k];
      if (wave_s[k] >= ppce_pkg::PHASE_MOD2) begin
        wave_m[k] = wave_s[k] - ppce_pkg::PHASE_MOD2;
      end else if (wave_s[k] >= ppce_pkg::PHASE_MOD) begin
        wave_m[k] = wave_s[k] - ppce_pkg::PHASE_MOD;
      end else begin
        wave_m[k] = wave_s[k];
      end
      if (hue == ppce_pkg::HUE_ALWAYS_HIGH) begin
        high[k] = 1'b1;
      end else if (hue == ppce_pkg::HUE_ALWAYS_LOW) begin
        high[k] = 1'b0;
      end else begin
        high[k] = (wave_m[k] < ppce_pkg::HALF_CYCLE);
      end
      win_raw[k] = sub_q[k][4:1];
      win_m[k]   = (win_raw[k] >= ppce_pkg::WINDOW_MOD) ? win_raw[k] - ppce_pkg::WINDOW_MOD
                                                        : win_raw[k];
      emph[k]    = |(pixel_i[8:6] & ppce_pkg::emph_window(win_m[k][2:0]));
      push_data_o.idx[k] = {high[k], emph[k], pixel_i[5:4]};
    end
    push_data_o.mute = (hue >= ppce_pkg::HUE_MUTE_MIN);
  end

  // update the phase on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (in_valid_i && push_ready_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppce_queue.sv -----
// Short queue that decouples the classifier from the arithmetic back end.
// Uses ppce_pkg for the entry type.
`default_nettype none

module ppce_queue #(
  parameter int Depth = ppce_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire ppce_pkg::op_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output ppce_pkg::op_t      pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ppce_pkg::op_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppce_back.sv -----
// Back end: sums the four levels with the black offset, scales by the gain,
// divides by 100, shifts and wraps to 8 bits. Holds the config registers.
// Uses ppce_pkg.
`default_nettype none

module ppce_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ppce_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ppce_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  wire logic                                pop_valid_i,
  output logic                                     pop_ready_o,
  input  wire ppce_pkg::op_t                       pop_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [ppce_pkg::LEVEL_W-1:0]      level_o
);

  localparam int SumW  = 21;
  localparam int ProdW = 30;
  localparam int MagW  = 28;
  localparam int QuoW  = 22;
  localparam int RecW  = MagW + 26;

  logic signed [ppce_pkg::OFFSET_W-1:0] offset_q;
  logic [ppce_pkg::GAIN_W-1:0]          gain_q;

  logic                    v1_q, v2_q, v3_q, v4_q;
  logic                    adv1, adv2, adv3, adv4;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [MagW-1:0]         mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [QuoW-1:0]         quo_q, quo_d;
  logic [RecW-1:0]         rec_prod;
  logic signed [ProdW-1:0] prod_abs;
  logic [MagW-1:0]         rem;
  logic [QuoW-1:0]         quo_fix;
  logic signed [QuoW:0]    quo_s;
  logic signed [ppce_pkg::LEVEL_W-1:0] level_q, level_d;

  assign cfg_ready_o = 1'b1;

  // write configuration registers, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      gain_q   <= ppce_pkg::GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ppce_pkg::REG_BLACK_OFFSET: offset_q <= cfg_data_i[ppce_pkg::OFFSET_W-1:0];
        ppce_pkg::REG_WHITE_GAIN:   gain_q   <= cfg_data_i[ppce_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage loads when it is empty or its successor moves
  assign adv4        = !v4_q || out_ready_i;
  assign adv3        = !v3_q || adv4;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign pop_ready_o = adv1;

  // stage 1: add the four levels (none for a muted word) and the black offset
  always_comb begin
    sum_d = SumW'(offset_q);
    if (!pop_data_i.mute) begin
      for (int k = 0; k < ppce_pkg::SUBSAMPLES; k++) begin
        sum_d = sum_d + SumW'(ppce_pkg::LEVEL_TABLE[pop_data_i.idx[k]]);
      end
    end
  end

  // stage 2: scale by the gain in percent
  assign prod_d = ProdW'(sum_q) * ProdW'($signed({1'b0, gain_q}));

  // stage 3: magnitude and reciprocal estimate of the quotient
  always_comb begin
    neg_d    = prod_q[ProdW-1];
    prod_abs = neg_d ? -prod_q : prod_q;
    mag_d    = prod_abs[MagW-1:0];
    rec_prod = RecW'(mag_d) * RecW'(ppce_pkg::RECIP_100);
    quo_d    = rec_prod[ppce_pkg::RECIP_SHIFT +: QuoW];
  end

  // stage 4: correct the quotient, restore the sign, shift and wrap
  always_comb begin
    rem     = mag_q - MagW'(MagW'(quo_q) * MagW'(ppce_pkg::DIV_CONST));
    quo_fix = (rem >= MagW'(ppce_pkg::DIV_CONST)) ? quo_q + 1'b1 : quo_q;
    quo_s   = neg_q ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix});
    level_d = quo_s[19:12];
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= pop_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv1) sum_q <= sum_d;
    if (adv2) prod_q <= prod_d;
    if (adv3) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      quo_q <= quo_d;
    end
    if (adv4) level_q <= level_d;
  end

  assign out_valid_o = v4_q;
  assign level_o     = level_q;

endmodule

`default_nettype wire

// ----- rtl/palette_pixel_composite_encoder.sv -----
// Top level of the palette pixel composite encoder.
// Instantiates ppce_front, ppce_queue and ppce_back; uses ppce_pkg.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_ready_o    | pixel_i, load_phase_i, start_phase_i
//   out     | output    | out_valid_o / out_ready_i  | level_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while out_ready_i holds; the 4-bit color phase
// update in the front end is the only loop between pixels. An accepted word
// passes the queue entry, then the sum, gain, reciprocal and fix stages.
// Reset clears the phase, the queue and the pipeline; no clearing pass.
// An output stall fills the pipeline, then the queue, then drops in_ready_o.
// Configuration writes are always taken in the cycle they are offered.
`default_nettype none

module palette_pixel_composite_encoder #(
  parameter int QueueDepth = ppce_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [ppce_pkg::PIXEL_W-1:0]    pixel_i,
  input  wire logic                            load_phase_i,
  input  wire logic [ppce_pkg::PHASE_W-1:0]    start_phase_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [ppce_pkg::LEVEL_W-1:0]  level_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ppce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ppce_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;
  ppce_pkg::op_t push_data, pop_data;

  // classify pixels and track the phase
  ppce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .load_phase_i  (load_phase_i),
    .start_phase_i (start_phase_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // buffer classified words
  ppce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // compute the composite sample
  ppce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level_o)
  );

endmodule

`default_nettype wire

// ----- rtl/ppce_checker.sv -----
// Port-level checks for the palette pixel composite encoder, bound to the
// top level. Uses ppce_pkg for widths.
`default_nettype none

module ppce_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic signed [ppce_pkg::LEVEL_W-1:0]  level_o,
  input wire logic                                 cfg_ready_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o))
    else $error("output word changed or dropped while stalled");

  // input backpressure only comes from a waiting output word
  a_full_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output word waiting");

  // reset leaves the pipeline empty and the queue open
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("pipeline not empty after reset");

  // configuration writes are never stalled
  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port stalled");

endmodule

bind palette_pixel_composite_encoder ppce_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .level_o     (level_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

// ----- dv/ppce_level_checker.sv -----
// Checker for the palette pixel composite encoder: watches the input, output and
// register channels, predicts every output level and compares it in order.
// Depends on ppce_pkg for port widths, register indexes and the gain reset value.
`timescale 1ns / 100ps

module ppce_level_checker
  import ppce_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [PIXEL_W-1:0]          pixel_i,
  input  logic                        load_phase_i,
  input  logic [PHASE_W-1:0]          start_phase_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [LEVEL_W-1:0]   level_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int         PHASE_CYCLE   = 12;
  localparam int         PHASE_ADVANCE = 3;
  localparam int         WAVE_HALF     = 6;
  localparam int         WINDOWS       = 6;
  localparam int         SUB_SAMPLES   = 4;
  localparam int         GAIN_DIVISOR  = 100;
  localparam int         FRAC_BITS     = 12;
  localparam logic [3:0] HUE_MUTED     = 4'd14;
  localparam logic [3:0] HUE_HIGH      = 4'd0;
  localparam logic [3:0] HUE_LOW       = 4'd13;

  // shadow copies of the block's state and registers
  logic [PHASE_W-1:0]         phase_now  = '0;
  logic signed [OFFSET_W-1:0] offset_reg = '0;
  logic [GAIN_W-1:0]          gain_reg   = GAIN_RESET;
  logic [LEVEL_W-1:0]         expected_levels [$];
  int                         mismatches = 0;
  int                         pending_q  = 0;
  int                         words_out  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_q;

  // level of one sub-sample, indexed by {high, emphasis, luma}
  function automatic int sub_level(input logic [3:0] idx);
    int lvl;
    case (idx)
      4'd0:    lvl = -12042;
      4'd1:    lvl = 0;
      4'd2:    lvl = 34406;
      4'd3:    lvl = 81427;
      4'd4:    lvl = -17203;
      4'd5:    lvl = -8028;
      4'd6:    lvl = 19497;
      4'd7:    lvl = 57342;
      4'd8:    lvl = 43581;
      4'd9:    lvl = 75693;
      4'd10:   lvl = 112965;
      4'd11:   lvl = 112965;
      4'd12:   lvl = 26951;
      4'd13:   lvl = 52181;
      default: lvl = 83721;
    endcase
    return lvl;
  endfunction

  // emphasis bits (red, green, blue from bit 0) that are live in a color window
  function automatic logic [2:0] window_mask(input int win);
    logic [2:0] mask;
    case (win)
      0:       mask = 3'b011;
      1:       mask = 3'b001;
      2:       mask = 3'b101;
      3:       mask = 3'b100;
      4:       mask = 3'b110;
      default: mask = 3'b010;
    endcase
    return mask;
  endfunction

  // sum four square-wave levels (none when muted), add the offset, apply gain, floor-shift, wrap
  function automatic logic [LEVEL_W-1:0] predict_level(input logic [PIXEL_W-1:0] pix,
                                                       input logic [PHASE_W-1:0] ph);
    int     hue;
    int     q;
    logic   high;
    logic   emph;
    longint acc;
    longint scaled;
    hue = int'(pix[3:0]);
    acc = longint'(offset_reg);
    for (int k = 0; k < SUB_SAMPLES; k++) begin
      q = int'(ph) + k;
      if (pix[3:0] < HUE_MUTED) begin
        if (pix[3:0] == HUE_HIGH) high = 1'b1;
        else if (pix[3:0] == HUE_LOW) high = 1'b0;
        else high = ((hue + q) % PHASE_CYCLE) < WAVE_HALF;
        emph = |(pix[8:6] & window_mask((q >> 1) % WINDOWS));
        acc += longint'(sub_level({high, emph, pix[5:4]}));
      end
    end
    // division truncates toward zero, the arithmetic shift floors
    scaled = (acc * longint'(gain_reg)) / GAIN_DIVISOR;
    scaled = scaled >>> FRAC_BITS;
    return scaled[LEVEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ppce_level_checker: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [LEVEL_W-1:0] want;
    logic [PHASE_W-1:0] ph;
    if (!rst_ni) begin
      phase_now  = '0;
      offset_reg = '0;
      gain_reg   = GAIN_RESET;
      expected_levels.delete();
      pending_q <= 0;
    end else begin
      // compare the word leaving the block with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("level %0d arrived with no word pending",
                                    level_i));
        end else begin
          want = expected_levels.pop_front();
          if (level_i !== want)
            report_mismatch($sformatf("level mismatch on word %0d: got %0d, want %0d",
                                      words_out, level_i, $signed(want)));
        end
        words_out++;
      end
      // follow register writes, drop unknown indexes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BLACK_OFFSET: offset_reg = cfg_data_i[OFFSET_W-1:0];
          REG_WHITE_GAIN:   gain_reg   = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      // predict the accepted pixel and advance the color phase
      if (in_valid_i && in_ready_i) begin
        ph = load_phase_i ? start_phase_i : phase_now;
        expected_levels.push_back(predict_level(pixel_i, ph));
        phase_now = PHASE_W'((int'(ph) + PHASE_ADVANCE) % PHASE_CYCLE);
      end
      pending_q <= expected_levels.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the palette pixel composite encoder: clock, reset, pixel and
// register stimulus, output back-pressure, watchdog and verdict.
// Depends on ppce_pkg, palette_pixel_composite_encoder and ppce_level_checker.
`timescale 1ns / 100ps

module tb;
  import ppce_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int IDLE_PCT        = 19;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 200;
  localparam int STEADY_PHASE    = 3;
  localparam int STEADY_FROM     = 700;
  localparam int STEADY_TO       = 900;
  localparam int HOLD_FIRST      = 300;
  localparam int HOLD_SECOND     = 1100;
  localparam int HOLD_CYCLES     = 64;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [OFFSET_W-1:0]  OFFSET_MAX  = 20'h7FFFF;
  localparam logic [OFFSET_W-1:0]  OFFSET_MIN  = 20'h80000;
  localparam logic [GAIN_W-1:0]    GAIN_MAX    = 8'hFF;
  localparam logic [GAIN_W-1:0]    GAIN_ZERO   = 8'h00;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic [PIXEL_W-1:0]          pixel       = '0;
  logic                        load_phase  = 1'b0;
  logic [PHASE_W-1:0]          start_phase = '0;
  logic                        out_ready   = 1'b0;
  logic                        cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index   = '0;
  logic [CFG_DAT_W-1:0]        cfg_data    = '0;
  logic                        in_ready;
  logic                        out_valid;
  logic                        cfg_ready;
  logic signed [LEVEL_W-1:0]   level;
  int                          fail_count;
  int                          pending;

  palette_pixel_composite_encoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_i       (pixel),
    .load_phase_i  (load_phase),
    .start_phase_i (start_phase),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .level_o       (level),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  ppce_level_checker u_level_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .pixel_i       (pixel),
    .load_phase_i  (load_phase),
    .start_phase_i (start_phase),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .level_i       (level),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // offer one pixel word and hold it until the block takes it
  task automatic offer_pixel(input logic [PIXEL_W-1:0] pix, input logic ld,
                             input logic [PHASE_W-1:0] sp);
    in_valid    <= 1'b1;
    pixel       <= pix;
    load_phase  <= ld;
    start_phase <= sp;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold one register write until taken; the caller drops valid afterwards
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write a spare index (ignored), then both registers; junk in the unused gain bits
  task automatic write_regs(input logic [OFFSET_W-1:0] offset, input logic [GAIN_W-1:0] gain);
    put_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_DAT_W'($urandom));
    put_reg(REG_BLACK_OFFSET, offset);
    put_reg(REG_WHITE_GAIN, {(CFG_DAT_W - GAIN_W)'($urandom), gain});
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every predicted word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls, a steady stretch and two long hold-offs
  initial begin : sink
    int taken;
    int hold_left;
    int holds_done;
    taken      = 0;
    hold_left  = 0;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (in_valid && in_ready) taken++;
      if (hold_left == 0 && holds_done < 2 &&
          taken >= ((holds_done == 0) ? HOLD_FIRST : HOLD_SECOND)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (taken >= STEADY_FROM && taken < STEADY_TO) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  // end the run when no channel moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    do @(posedge clk); while (!rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      @(posedge clk);
    end
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [3:0]          hv;
    logic                ld;
    logic [PHASE_W-1:0]  sp;
    logic [OFFSET_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;
    bit                  steady;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every hue, mixed luma and emphasis, at the reset register values
    for (int h = 0; h < 16; h++) begin
      hv = 4'(h);
      offer_pixel({hv[2:0], hv[3:2], hv}, hv == 4'd9, PHASE_W'(h % 12));
    end
    // field extremes and phase reloads, including start phases above eleven
    offer_pixel(9'h000, 1'b1, 4'd0);
    offer_pixel(9'h1FF, 1'b1, 4'd11);
    offer_pixel(9'h1F0, 1'b1, 4'd12);
    offer_pixel(9'h0F1, 1'b1, 4'd13);
    offer_pixel(9'h13C, 1'b1, 4'd14);
    offer_pixel(9'h1C5, 1'b1, 4'd15);
    offer_pixel(9'h000, 1'b0, 4'hF);

    // random phases, first at the register extremes and reset values, then at random settings
    for (int p = 0; p < PHASES; p++) begin
      drain_words();
      case (p)
        0: begin offset = OFFSET_MAX; gain = GAIN_MAX;   end
        1: begin offset = OFFSET_MIN; gain = GAIN_MAX;   end
        2: begin offset = OFFSET_MAX; gain = GAIN_ZERO;  end
        3: begin offset = '0;         gain = GAIN_RESET; end
        default: begin
          if ($urandom_range(1) == 0)
            offset = OFFSET_W'($urandom);
          else
            offset = OFFSET_W'(int'($urandom_range(0, 120000)) - 60000);
          gain = GAIN_W'($urandom_range(0, 255));
        end
      endcase
      write_regs(offset, gain);
      steady = (p == STEADY_PHASE);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        ld = ($urandom_range(7) == 0);
        if (ld && $urandom_range(7) != 0)
          sp = PHASE_W'($urandom_range(0, 11));
        else
          sp = PHASE_W'($urandom);
        offer_pixel(PIXEL_W'($urandom), ld, sp);
      end
    end
    drain_words();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
